[hdl/uart_tx_rx_ring_buffers_assert.svh]
// assertion macros for the ring buffer block
`ifndef UART_TX_RX_RING_BUFFERS_ASSERT_SVH
`define UART_TX_RX_RING_BUFFERS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring buffer assertion failed");

// next-cycle implication, checked outside reset
`define RB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring buffer assertion failed");

`endif

[hdl/uart_rb_pkg.sv]
`default_nettype none
package uart_rb_pkg;

  localparam int BYTE_W = 8;
  localparam int DEFAULT_RING_DEPTH = 256;

  typedef enum logic [1:0] {
    OP_SEND   = 2'd0,
    OP_READ   = 2'd1,
    OP_RECV   = 2'd2,
    OP_TXDONE = 2'd3
  } op_t;

endpackage
`default_nettype wire

[hdl/uart_rb_ram.sv]
`default_nettype none
module uart_rb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/uart_tx_rx_ring_buffers.sv]
`default_nettype none
// Transmit and receive byte rings for a UART. Each item is one operation: queue a byte to send,
// read a received byte, store a byte received from the line, or signal transmit done. Every
// item gives exactly one result with the popped byte (or an empty flag), the byte to load into
// the transmitter if any, and the number of received bytes waiting (saturating at 255). In the
// accept cycle the pointers update and the ring memory access is issued, and in the next cycle
// the registered memory read is captured into the output register. The next item is taken at
// the earliest in the cycle after that, at the edge where the previous result is taken, so a new
// item is accepted only once the previous one has reached the output register; while a result
// is stalled the input is stalled too. A full ring silently overwrites, and a transmit done with
// nothing queued is ignored.
module uart_tx_rx_ring_buffers
  import uart_rb_pkg::*;
#(
  parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        operation,
  input  wire logic [BYTE_W-1:0] data_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [BYTE_W-1:0] read_byte,
  output logic                   read_empty,
  output logic                   line_load,
  output logic      [BYTE_W-1:0] line_byte,
  output logic      [BYTE_W-1:0] bytes_waiting
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = (PTR_W + 1 > 9) ? PTR_W + 1 : 9;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef enum logic {ST_IDLE, ST_PEND} state_t;

  function automatic ptr_t ring_next(input ptr_t p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [BYTE_W-1:0] ring_count(input ptr_t head, input ptr_t tail);
    logic [CNT_W-1:0] h;
    logic [CNT_W-1:0] t;
    logic [CNT_W-1:0] c;
    h = CNT_W'(head);
    t = CNT_W'(tail);
    c = (h >= t) ? (h - t) : (CNT_W'(RING_DEPTH) - t + h);
    return (c > CNT_W'(255)) ? 8'hFF : c[BYTE_W-1:0];
  endfunction

  state_t state;
  ptr_t send_head, send_tail, receive_head, receive_tail;
  ptr_t send_tail_next;
  op_t pend_op;
  logic pend_empty;
  logic pend_load;
  logic [BYTE_W-1:0] pend_byte;
  logic [BYTE_W-1:0] tx_rdata, rx_rdata;
  logic in_take;
  op_t op_in;
  logic tx_we, rx_we;

  assign op_in = op_t'(operation);
  assign in_stall = (state == ST_PEND) || (out_valid && out_stall);
  assign in_take = in_valid && !in_stall;
  assign send_tail_next = ring_next(send_tail);
  assign tx_we = in_take && (op_in == OP_SEND);
  assign rx_we = in_take && (op_in == OP_RECV);

  uart_rb_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (send_head),
    .wdata (data_byte),
    .raddr (send_tail_next),
    .rdata (tx_rdata)
  );

  uart_rb_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (receive_head),
    .wdata (data_byte),
    .raddr (receive_tail),
    .rdata (rx_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      send_head    <= '0;
      send_tail    <= '0;
      receive_head <= '0;
      receive_tail <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
          if (in_take) begin
            state      <= ST_PEND;
            pend_op    <= op_in;
            pend_byte  <= data_byte;
            pend_empty <= 1'b0;
            pend_load  <= 1'b0;
            unique case (op_in)
              OP_SEND: begin
                pend_load <= (send_head == send_tail);
                send_head <= ring_next(send_head);
              end
              OP_READ: begin
                if (receive_head == receive_tail) begin
                  pend_empty <= 1'b1;
                end else begin
                  receive_tail <= ring_next(receive_tail);
                end
              end
              OP_RECV: begin
                receive_head <= ring_next(receive_head);
              end
              OP_TXDONE: begin
                if (send_head != send_tail) begin
                  send_tail <= send_tail_next;
                  pend_load <= (send_head != send_tail_next);
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_PEND: begin
          state         <= ST_IDLE;
          out_valid     <= 1'b1;
          read_empty    <= pend_empty;
          line_load     <= pend_load;
          read_byte     <= (pend_op == OP_READ && !pend_empty) ? rx_rdata : '0;
          line_byte     <= !pend_load ? '0 : (pend_op == OP_SEND) ? pend_byte : tx_rdata;
          bytes_waiting <= ring_count(receive_head, receive_tail);
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "uart_tx_rx_ring_buffers_assert.svh"

  `RB_ASSERT_NEXT(a_take_pending, in_take, state == ST_PEND)
  `RB_ASSERT_NEXT(a_pend_result, state == ST_PEND, out_valid)
  `RB_ASSERT_IMPL(a_empty_zero, out_valid && read_empty, read_byte == 8'd0)
  `RB_ASSERT_IMPL(a_no_load_zero, out_valid && !line_load, line_byte == 8'd0)

endmodule
`default_nettype wire

[tb/uart_tx_rx_ring_buffers_tb.sv]
`default_nettype none
module uart_tx_rx_ring_buffers_tb;
  import uart_rb_pkg::*;

  localparam int DEPTH = DEFAULT_RING_DEPTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [BYTE_W-1:0] read_byte;
    logic              read_empty;
    logic              line_load;
    logic [BYTE_W-1:0] line_byte;
    logic [BYTE_W-1:0] bytes_waiting;
  } ring_result_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        operation;
  logic [BYTE_W-1:0] data_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] read_byte;
  logic              read_empty;
  logic              line_load;
  logic [BYTE_W-1:0] line_byte;
  logic [BYTE_W-1:0] bytes_waiting;

  // shadow copy of both rings
  logic [BYTE_W-1:0] tx_ring [DEPTH];
  logic [BYTE_W-1:0] rx_ring [DEPTH];
  int tx_head = 0;
  int tx_tail = 0;
  int rx_head = 0;
  int rx_tail = 0;

  ring_result_t ring_results_q[$];
  int error_count = 0;
  int cycle_count = 0;
  int tx_idle_pct = 15;
  int rx_idle_pct = 61;
  int hold_left = 0;

  uart_tx_rx_ring_buffers #(
    .RING_DEPTH(DEPTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_byte    (read_byte),
    .read_empty   (read_empty),
    .line_load    (line_load),
    .line_byte    (line_byte),
    .bytes_waiting(bytes_waiting)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic ring_result_t compute_ring_result(op_t op, logic [BYTE_W-1:0] b);
    ring_result_t r;
    int cnt;
    r.read_byte = '0;
    r.read_empty = 1'b0;
    r.line_load = 1'b0;
    r.line_byte = '0;
    unique case (op)
      OP_SEND: begin
        tx_ring[tx_head] = b;
        if (tx_head == tx_tail) begin
          r.line_load = 1'b1;
          r.line_byte = b;
        end
        tx_head = (tx_head + 1) % DEPTH;
      end
      OP_READ: begin
        if (rx_head == rx_tail) begin
          r.read_empty = 1'b1;
        end else begin
          r.read_byte = rx_ring[rx_tail];
          rx_tail = (rx_tail + 1) % DEPTH;
        end
      end
      OP_RECV: begin
        rx_ring[rx_head] = b;
        rx_head = (rx_head + 1) % DEPTH;
      end
      default: begin
        // transmit done with nothing queued is ignored
        if (tx_head != tx_tail) begin
          tx_tail = (tx_tail + 1) % DEPTH;
          if (tx_head != tx_tail) begin
            r.line_load = 1'b1;
            r.line_byte = tx_ring[tx_tail];
          end
        end
      end
    endcase
    cnt = (rx_head - rx_tail + DEPTH) % DEPTH;
    if (cnt > 255) cnt = 255;
    r.bytes_waiting = cnt[BYTE_W-1:0];
    return r;
  endfunction

  // result check first, then prediction of the item taken at this edge
  always @(posedge clk) begin : monitor
    ring_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (ring_results_q.size() == 0) begin
          $error("result with no item pending");
          error_count++;
        end else begin
          want = ring_results_q.pop_front();
          if (read_byte !== want.read_byte) begin
            $error("read_byte expected %0h actual %0h", want.read_byte, read_byte);
            error_count++;
          end
          if (read_empty !== want.read_empty) begin
            $error("read_empty expected %0b actual %0b", want.read_empty, read_empty);
            error_count++;
          end
          if (line_load !== want.line_load) begin
            $error("line_load expected %0b actual %0b", want.line_load, line_load);
            error_count++;
          end
          if (line_byte !== want.line_byte) begin
            $error("line_byte expected %0h actual %0h", want.line_byte, line_byte);
            error_count++;
          end
          if (bytes_waiting !== want.bytes_waiting) begin
            $error("bytes_waiting expected %0d actual %0d", want.bytes_waiting, bytes_waiting);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        ring_results_q.push_back(compute_ring_result(op_t'(operation), data_byte));
      end
    end
  end

  // receiver side: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(op_t op, logic [BYTE_W-1:0] b);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic op_t pick_op();
    int w;
    w = $urandom_range(99);
    if (w < 30) return OP_SEND;
    if (w < 55) return OP_READ;
    if (w < 85) return OP_RECV;
    return OP_TXDONE;
  endfunction

  task automatic test_empty_rings();
    send_item(OP_READ, 8'hff);
    send_item(OP_TXDONE, 8'h00);
    send_item(OP_READ, 8'h00);
  endtask

  task automatic test_send_path();
    send_item(OP_SEND, 8'h00);
    send_item(OP_SEND, 8'hff);
    send_item(OP_SEND, 8'h5a);
    send_item(OP_TXDONE, 8'hff);
    send_item(OP_TXDONE, 8'h00);
    send_item(OP_TXDONE, 8'h00);
    // spurious transmit done
    send_item(OP_TXDONE, 8'h00);
    send_item(OP_SEND, 8'ha5);
    send_item(OP_TXDONE, 8'h00);
  endtask

  task automatic test_receive_path();
    send_item(OP_RECV, 8'h00);
    send_item(OP_RECV, 8'hff);
    send_item(OP_RECV, 8'h5a);
    send_item(OP_READ, 8'h00);
    send_item(OP_READ, 8'h00);
    send_item(OP_READ, 8'hff);
    send_item(OP_READ, 8'h00);
  endtask

  task automatic test_full_rings();
    // receive ring up to the saturating count, then one more wraps it to empty
    repeat (DEPTH - 1) send_item(OP_RECV, 8'($urandom_range(255)));
    send_item(OP_RECV, 8'h81);
    send_item(OP_READ, 8'h00);
    repeat (3) send_item(OP_RECV, 8'($urandom_range(255)));
    repeat (4) send_item(OP_READ, 8'h00);
    // send ring overwritten, then queued onto the wrapped ring
    repeat (DEPTH) send_item(OP_SEND, 8'($urandom_range(255)));
    send_item(OP_TXDONE, 8'h00);
    send_item(OP_SEND, 8'h3c);
    send_item(OP_TXDONE, 8'h00);
    send_item(OP_TXDONE, 8'h00);
  endtask

  task automatic test_backpressure();
    hold_left <= 300;
    repeat (60) send_item(pick_op(), 8'($urandom_range(255)));
  endtask

  task automatic test_random(int count);
    int burst_left;
    op_t burst_op;
    op_t op;
    burst_left = 0;
    burst_op = OP_SEND;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0 && $urandom_range(99) < 5) begin
        burst_op = pick_op();
        burst_left = $urandom_range(8, 24);
      end
      if (burst_left > 0) begin
        op = burst_op;
        burst_left--;
      end else begin
        op = pick_op();
      end
      send_item(op, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_SEND;
    data_byte = '0;
    out_stall = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 15;
    rx_idle_pct = 61;
    test_empty_rings();
    test_send_path();
    test_receive_path();
    test_full_rings();
    test_backpressure();
    test_random(340);

    tx_idle_pct = 61;
    rx_idle_pct = 15;
    test_random(330);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(330);

    in_valid <= 1'b0;
    while (ring_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
+incdir+hdl
hdl/uart_rb_pkg.sv
hdl/uart_rb_ram.sv
hdl/uart_tx_rx_ring_buffers.sv
tb/uart_tx_rx_ring_buffers_tb.sv
